// ===== hdl/seaf_pkg.sv =====
package seaf_pkg;

    // Commands carried in s_tuser
    localparam logic [1:0] CMD_START_RD = 2'd0;
    localparam logic [1:0] CMD_START_WR = 2'd1;
    localparam logic [1:0] CMD_RESPONSE = 2'd2;

    // Response states
    localparam logic [1:0] RSP_RECEIVED  = 2'd0;
    localparam logic [1:0] RSP_TIMED_OUT = 2'd1;

    // Datagram kinds
    localparam logic [1:0] DG_APWR = 2'd0;
    localparam logic [1:0] DG_NPWR = 2'd1;
    localparam logic [1:0] DG_APRD = 2'd2;
    localparam logic [1:0] DG_NPRD = 2'd3;

    // Sequencer status
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;
    localparam logic [1:0] ST_ERROR   = 2'd3;

    // Error causes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NO_RX      = 3'd1;
    localparam logic [2:0] ERR_BAD_WKC    = 3'd2;
    localparam logic [2:0] ERR_BUSY_TMO   = 3'd3;
    localparam logic [2:0] ERR_WR_FAILED  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_TIMEOUT_TICKS = 1'b0;
    localparam logic CFG_RETRY_LIMIT   = 1'b1;

    localparam logic [31:0] TIMEOUT_RESET = 32'd10000000;
    localparam logic [7:0]  RETRY_RESET   = 8'd3;

    // SII control bytes and status bits
    localparam logic [7:0]  SII_CTRL_RD0   = 8'h00;
    localparam logic [7:0]  SII_CTRL_RD1   = 8'h01;
    localparam logic [7:0]  SII_CTRL_WR0   = 8'h01;
    localparam logic [7:0]  SII_CTRL_WR1   = 8'h02;
    localparam logic [7:0]  SII_BUSY_RD    = 8'h81;
    localparam logic [7:0]  SII_BUSY_WR    = 8'h82;
    localparam logic [7:0]  SII_ERR_BIT    = 8'h40;
    localparam logic [15:0] WKC_OK         = 16'd1;

    localparam logic [3:0] LEN_RD_INIT = 4'd4;
    localparam logic [3:0] LEN_RD_POLL = 4'd10;
    localparam logic [3:0] LEN_WR_INIT = 4'd8;
    localparam logic [3:0] LEN_WR_POLL = 4'd2;

    localparam int IN_TDATA_W  = 176;
    localparam int OUT_TDATA_W = 128;

    typedef struct packed {
        logic [31:0] timeout_ticks;
        logic [7:0]  retry_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] slave_address;
        logic        node_addressing;
        logic [15:0] word_offset;
        logic [15:0] write_word;
        logic [1:0]  response_state;
        logic [15:0] wkc;
        logic [7:0]  status_byte;
        logic [31:0] response_data;
        logic [31:0] sent_time;
        logic [31:0] received_time;
    } in_item_t;

    typedef struct packed {
        logic        send_request;
        logic [1:0]  datagram_kind;
        logic [15:0] datagram_address;
        logic [3:0]  datagram_length;
        logic [63:0] datagram_payload;
        logic [1:0]  status;
        logic [2:0]  error_cause;
        logic [31:0] read_value;
    } out_item_t;

endpackage

// ===== hdl/seaf_fsm.sv =====
module seaf_fsm
    import seaf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      step,
    input  in_item_t  item,
    output out_item_t result
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_RD_INIT = 3'd1,
        PH_RD_POLL = 3'd2,
        PH_WR_INIT = 3'd3,
        PH_WR_POLL = 3'd4,
        PH_RD_DONE = 3'd5,
        PH_WR_DONE = 3'd6,
        PH_ERROR   = 3'd7
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  retries_reg, retries_next;
    logic [31:0] poll_start_reg, poll_start_next;
    logic        one_more_reg, one_more_next;
    logic [15:0] target_reg, target_next;
    logic        node_reg, node_next;
    logic [15:0] offset_reg, offset_next;
    logic [31:0] data_reg, data_next;
    logic [2:0]  err_reg, err_next;
    out_item_t   result_reg, result_next;

    logic        running;
    logic        send;
    logic [7:0]  busy_mask;
    logic [31:0] elapsed;

    assign running   = (phase_reg == PH_RD_INIT) || (phase_reg == PH_RD_POLL) ||
                       (phase_reg == PH_WR_INIT) || (phase_reg == PH_WR_POLL);
    assign busy_mask = (phase_reg == PH_RD_POLL) ? SII_BUSY_RD : SII_BUSY_WR;
    assign elapsed   = item.received_time - poll_start_reg;

    always_comb begin
        phase_next      = phase_reg;
        retries_next    = retries_reg;
        poll_start_next = poll_start_reg;
        one_more_next   = one_more_reg;
        target_next     = target_reg;
        node_next       = node_reg;
        offset_next     = offset_reg;
        data_next       = data_reg;
        err_next        = err_reg;
        send            = 1'b0;
        result_next     = '0;

        if (item.command == CMD_START_RD || item.command == CMD_START_WR) begin
            target_next  = item.slave_address;
            offset_next  = item.word_offset;
            retries_next = cfg.retry_limit;
            err_next     = ERR_NONE;
            send         = 1'b1;
            if (item.command == CMD_START_RD) begin
                node_next  = item.node_addressing;
                data_next  = '0;
                phase_next = PH_RD_INIT;
            end else begin
                node_next  = 1'b1;
                data_next  = {16'd0, item.write_word};
                phase_next = PH_WR_INIT;
            end
        end else if (item.command == CMD_RESPONSE && running) begin
            if (item.response_state == RSP_TIMED_OUT && retries_reg != 8'd0) begin
                retries_next = retries_reg - 8'd1;
                send         = 1'b1;
            end else if (item.response_state != RSP_RECEIVED) begin
                phase_next = PH_ERROR;
                err_next   = ERR_NO_RX;
            end else if (item.wkc != WKC_OK) begin
                phase_next = PH_ERROR;
                err_next   = ERR_BAD_WKC;
            end else if (phase_reg == PH_RD_INIT || phase_reg == PH_WR_INIT) begin
                poll_start_next = item.sent_time;
                one_more_next   = 1'b1;
                retries_next    = cfg.retry_limit;
                phase_next      = (phase_reg == PH_RD_INIT) ? PH_RD_POLL : PH_WR_POLL;
                send            = 1'b1;
            end else if ((item.status_byte & busy_mask) != 8'd0) begin
                // still busy: poll again, with one grace poll past the deadline
                if (elapsed >= cfg.timeout_ticks && !one_more_reg) begin
                    phase_next = PH_ERROR;
                    err_next   = ERR_BUSY_TMO;
                end else begin
                    if (elapsed >= cfg.timeout_ticks) begin
                        one_more_next = 1'b0;
                    end
                    retries_next = cfg.retry_limit;
                    send         = 1'b1;
                end
            end else if (phase_reg == PH_RD_POLL) begin
                data_next  = item.response_data;
                phase_next = PH_RD_DONE;
            end else if ((item.status_byte & SII_ERR_BIT) != 8'd0) begin
                phase_next = PH_ERROR;
                err_next   = ERR_WR_FAILED;
            end else begin
                phase_next = PH_WR_DONE;
            end
        end

        if (send) begin
            result_next.send_request     = 1'b1;
            result_next.datagram_address = target_next;
            case (phase_next)
                PH_RD_INIT: begin
                    result_next.datagram_kind    = node_next ? DG_NPWR : DG_APWR;
                    result_next.datagram_length  = LEN_RD_INIT;
                    result_next.datagram_payload = {32'd0, offset_next,
                                                    SII_CTRL_RD1, SII_CTRL_RD0};
                end
                PH_RD_POLL: begin
                    result_next.datagram_kind    = node_next ? DG_NPRD : DG_APRD;
                    result_next.datagram_length  = LEN_RD_POLL;
                end
                PH_WR_INIT: begin
                    result_next.datagram_kind    = DG_NPWR;
                    result_next.datagram_length  = LEN_WR_INIT;
                    result_next.datagram_payload = {data_next[15:0], 16'd0, offset_next,
                                                    SII_CTRL_WR1, SII_CTRL_WR0};
                end
                PH_WR_POLL: begin
                    result_next.datagram_kind    = DG_NPRD;
                    result_next.datagram_length  = LEN_WR_POLL;
                end
                default: begin
                    result_next.send_request     = 1'b0;
                    result_next.datagram_address = '0;
                end
            endcase
        end

        case (phase_next)
            PH_IDLE: begin
                result_next.status = ST_IDLE;
            end
            PH_RD_DONE: begin
                result_next.status     = ST_DONE;
                result_next.read_value = data_next;
            end
            PH_WR_DONE: begin
                result_next.status = ST_DONE;
            end
            PH_ERROR: begin
                result_next.status      = ST_ERROR;
                result_next.error_cause = err_next;
            end
            default: begin
                result_next.status = ST_RUNNING;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            retries_reg    <= '0;
            poll_start_reg <= '0;
            one_more_reg   <= 1'b0;
            target_reg     <= '0;
            node_reg       <= 1'b0;
            offset_reg     <= '0;
            data_reg       <= '0;
            err_reg        <= ERR_NONE;
        end else if (step) begin
            phase_reg      <= phase_next;
            retries_reg    <= retries_next;
            poll_start_reg <= poll_start_next;
            one_more_reg   <= one_more_next;
            target_reg     <= target_next;
            node_reg       <= node_next;
            offset_reg     <= offset_next;
            data_reg       <= data_next;
            err_reg        <= err_next;
        end
        if (step) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== hdl/slave_eeprom_access_fsm_unit.sv =====
// EEPROM access sequencer for a slave information interface.
// Input stream: one word per command. s_tuser carries the command (start read,
// start write, datagram response event); s_tdata carries the addressing,
// write data and, for response events, the returned datagram's state, working
// counter, status byte, data and timestamps.
// Output stream: exactly one word per accepted input word, giving the datagram
// to send next (if any) plus the sequencer status, error cause and read value.
// Latency: the result word is valid the cycle after the input word is taken.
// Throughput: one word per cycle unless stalled; all decisions are a single pass
// of logic from the accepted word and the phase registers into the output register.
// Stall: s_tready = output register empty or being taken this cycle, so the
// block keeps accepting while the receiver drains, and holds when it stalls.
// Config: cfg_wr_en/cfg_index/cfg_wdata write timeout_ticks (index 0) and
// retry_limit (index 1); write only while idle.
// Reset (aresetn low, synchronous): phase idle, counters cleared, output empty,
// timeout_ticks = 10000000, retry_limit = 3.
module slave_eeprom_access_fsm_unit
    import seaf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write port
    input  logic                   cfg_wr_en,
    input  logic                   cfg_index,
    input  logic [31:0]            cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata, low bit up: slave_address[15:0], node_addressing[16],
    // word_offset[32:17], write_word[48:33], response_state[50:49],
    // wkc[66:51], status_byte[74:67], response_data[106:75],
    // sent_time[138:107], received_time[170:139], zero fill[175:171]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: command[1:0]
    input  logic [1:0]             s_tuser,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata, low bit up: send_request[0], datagram_kind[2:1],
    // datagram_address[18:3], datagram_length[22:19], datagram_payload[86:23],
    // status[88:87], error_cause[91:89], read_value[123:92], zero fill[127:124]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cfg_t      cfg_reg;
    logic      m_valid_reg, m_valid_next;
    logic      step;
    in_item_t  item;
    out_item_t result;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
            cfg_reg.retry_limit   <= RETRY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_wdata;
                CFG_RETRY_LIMIT:   cfg_reg.retry_limit   <= cfg_wdata[7:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Output register handshake: take a new word whenever the slot frees up
    assign s_tready = !m_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Unpack the input word
    assign item.command         = s_tuser;
    assign item.slave_address   = s_tdata[15:0];
    assign item.node_addressing = s_tdata[16];
    assign item.word_offset     = s_tdata[32:17];
    assign item.write_word      = s_tdata[48:33];
    assign item.response_state  = s_tdata[50:49];
    assign item.wkc             = s_tdata[66:51];
    assign item.status_byte     = s_tdata[74:67];
    assign item.response_data   = s_tdata[106:75];
    assign item.sent_time       = s_tdata[138:107];
    assign item.received_time   = s_tdata[170:139];

    seaf_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step    (step),
        .item    (item),
        .result  (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0,
                       result.read_value,
                       result.error_cause,
                       result.status,
                       result.datagram_payload,
                       result.datagram_length,
                       result.datagram_address,
                       result.datagram_kind,
                       result.send_request};

`ifndef NO_ASSERTIONS
    // An accepted word always shows up in the output register next cycle
    a_step_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid_reg)
        else $error("accepted word did not reach output register");

    // Error cause only reported together with error status
    a_cause_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result.error_cause != ERR_NONE) |-> result.status == ST_ERROR)
        else $error("error cause without error status");

    // Read value only nonzero with done status
    a_value_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result.read_value != 32'd0) |-> result.status == ST_DONE)
        else $error("read value outside done status");

    // No datagram means zero length, payload and address; a datagram implies running
    a_dgram_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !result.send_request) |->
            (result.datagram_length == 4'd0 && result.datagram_payload == 64'd0 &&
             result.datagram_address == 16'd0))
        else $error("datagram fields set without send request");

    a_send_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result.send_request) |-> result.status == ST_RUNNING)
        else $error("send request while not running");
`endif

endmodule
